@@ rtl/core/lge_pkg.sv @@
package lge_pkg;

  // fixed field widths of the item ports
  localparam int ROW_IDX_W = 5;
  localparam int BITS_W    = 64;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_STEP  = 2'd2;

  typedef struct packed {
    logic [1:0]           mode;
    logic [ROW_IDX_W-1:0] row_index;
    logic [BITS_W-1:0]    row_bits;
  } in_item_t;

  typedef struct packed {
    logic [ROW_IDX_W-1:0] out_row;
    logic [BITS_W-1:0]    out_bits;
    logic                 last_row;
    logic                 evolving;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_PRIME,
    ST_READ,
    ST_CALC,
    ST_DONE
  } lge_state_t;

endpackage

@@ rtl/core/lge_rule.sv @@
module lge_rule #(
  parameter int WORLD_WIDTH = 64
) (
  input  logic [WORLD_WIDTH-1:0] above,
  input  logic [WORLD_WIDTH-1:0] mid,
  input  logic [WORLD_WIDTH-1:0] below,
  output logic [WORLD_WIDTH-1:0] next_cells
);
  import lge_pkg::*;

  logic [WORLD_WIDTH+1:0] up_p, mid_p, dn_p;

  // dead cells pad both borders
  assign up_p  = {1'b0, above, 1'b0};
  assign mid_p = {1'b0, mid, 1'b0};
  assign dn_p  = {1'b0, below, 1'b0};

  always_comb begin
    logic [3:0] n;
    next_cells = '0;
    for (int c = 0; c < WORLD_WIDTH; c++) begin
      n = {3'b0, up_p[c]} + {3'b0, up_p[c+1]} + {3'b0, up_p[c+2]}
        + {3'b0, mid_p[c]} + {3'b0, mid_p[c+2]}
        + {3'b0, dn_p[c]} + {3'b0, dn_p[c+1]} + {3'b0, dn_p[c+2]};
      next_cells[c] = (n == 4'd3) || ((n == 4'd2) && mid[c]);
    end
  end

endmodule

@@ rtl/core/life_generation_with_stall_check.sv @@
// Bounded B3/S23 life engine with a ring of older generations and a stall check.
// Input channel: an item is taken on a clock edge with start high and busy low.
//   load  : writes one row of the current generation, done in that cycle
//   clear : zeroes every older generation, busy until the sweep ends, one
//           memory entry per cycle, the current generation's entries unwritten
//   step  : ages the ring and computes the next generation, busy meanwhile
// A step emits WORLD_HEIGHT result items on out_strobe/out_item, one row at a
// time, each row passing through a READ and a CALC state. It takes both because
// the generation memory has two read ports and a row needs three reads: the row
// below, and the same row two and six generations back. The last row carries
// last_row and the evolving flag.
// Results are shown for exactly one cycle; the receiver cannot stall them.
// Mode 3 and loads of a row beyond the world are dropped without a result.
// Reset (rst_n low, synchronous) starts a pass that zeroes the whole memory
// with busy high; no item is taken meanwhile.
module life_generation_with_stall_check #(
  parameter int WORLD_WIDTH   = 64,
  parameter int WORLD_HEIGHT  = 32,
  parameter int HISTORY_DEPTH = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  lge_pkg::in_item_t  in_item,
  output logic               busy,
  output logic               out_strobe,
  output lge_pkg::out_item_t out_item
);
  import lge_pkg::*;

  localparam int SW = $clog2(HISTORY_DEPTH);
  localparam int RW = $clog2(WORLD_HEIGHT);
  localparam logic [SW-1:0] SLOT_LAST = SW'(HISTORY_DEPTH - 1);
  localparam logic [RW-1:0] ROW_LAST  = RW'(WORLD_HEIGHT - 1);
  // from the old head, two back of the new head is one ahead, six back is five
  localparam logic [SW:0]   AHEAD_SIX = (SW+1)'(5);
  localparam logic [SW:0]   DEPTH_EXT = (SW+1)'(HISTORY_DEPTH);

  logic [WORLD_WIDTH-1:0] gen_mem [HISTORY_DEPTH][WORLD_HEIGHT];

  lge_state_t state_r, state_nxt;
  logic          keep_cur_r;
  logic [SW-1:0] sw_slot_r;
  logic [RW-1:0] sw_row_r;
  logic [SW-1:0] head_r, cur_s_r, new_s_r, two_s_r, six_s_r;
  logic [RW-1:0] row_r, nr_row_r;
  logic [WORLD_WIDTH-1:0] w_prev_r, w_cur_r, nr_r, rd_a_r, rd_b_r;
  logic          same_two_r, same_six_r;
  logic          out_strobe_r;
  out_item_t     out_r;

  logic                   accept;
  logic                   load_ok;
  logic [SW-1:0]          newh, two_s, six_s;
  logic [SW:0]            six_sum;
  logic [WORLD_WIDTH-1:0] below, rule_out;

  logic                   wr_en;
  logic [SW-1:0]          wr_slot, rd_a_slot, rd_b_slot;
  logic [RW-1:0]          wr_row, rd_a_row, rd_b_row;
  logic [WORLD_WIDTH-1:0] wr_data;

  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && (state_r == ST_IDLE);
  assign load_ok    = ({27'b0, in_item.row_index} < 32'(WORLD_HEIGHT));
  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

  assign newh    = (head_r == '0) ? SLOT_LAST : head_r - 1'b1;
  assign two_s   = (head_r == SLOT_LAST) ? '0 : head_r + 1'b1;
  assign six_sum = {1'b0, head_r} + AHEAD_SIX;
  assign six_s   = (six_sum >= DEPTH_EXT) ? SW'(six_sum - DEPTH_EXT) : SW'(six_sum);

  assign below = (row_r == ROW_LAST) ? '0 : rd_a_r;

  lge_rule #(
    .WORLD_WIDTH(WORLD_WIDTH)
  ) u_rule (
    .above     (w_prev_r),
    .mid       (w_cur_r),
    .below     (below),
    .next_cells(rule_out)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_SWEEP: begin
        if (sw_slot_r == SLOT_LAST && sw_row_r == ROW_LAST) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && in_item.mode == MODE_CLEAR) state_nxt = ST_SWEEP;
        else if (accept && in_item.mode == MODE_STEP) state_nxt = ST_PRIME;
      end
      ST_PRIME: state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_CALC;
      ST_CALC: begin
        state_nxt = (row_r == ROW_LAST) ? ST_DONE : ST_READ;
      end
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    wr_en     = 1'b0;
    wr_slot   = '0;
    wr_row    = '0;
    wr_data   = '0;
    rd_a_slot = '0;
    rd_a_row  = '0;
    rd_b_slot = '0;
    rd_b_row  = '0;
    case (state_r)
      ST_SWEEP: begin
        wr_en   = !(keep_cur_r && sw_slot_r == head_r);
        wr_slot = sw_slot_r;
        wr_row  = sw_row_r;
      end
      ST_IDLE: begin
        wr_en   = accept && in_item.mode == MODE_LOAD && load_ok;
        wr_slot = head_r;
        wr_row  = RW'(in_item.row_index);
        wr_data = in_item.row_bits[WORLD_WIDTH-1:0];
      end
      ST_PRIME: begin
        rd_a_slot = cur_s_r;
      end
      ST_READ: begin
        rd_a_slot = cur_s_r;
        rd_a_row  = (row_r == ROW_LAST) ? row_r : row_r + 1'b1;
        rd_b_slot = two_s_r;
        rd_b_row  = row_r;
      end
      ST_CALC: begin
        wr_en     = 1'b1;
        wr_slot   = new_s_r;
        wr_row    = row_r;
        wr_data   = rule_out;
        rd_b_slot = six_s_r;
        rd_b_row  = row_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) gen_mem[wr_slot][wr_row] <= wr_data;
    rd_a_r <= gen_mem[rd_a_slot][rd_a_row];
    rd_b_r <= gen_mem[rd_b_slot][rd_b_row];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_SWEEP;
      keep_cur_r   <= 1'b0;
      sw_slot_r    <= '0;
      sw_row_r     <= '0;
      head_r       <= '0;
      row_r        <= '0;
      same_two_r   <= 1'b1;
      same_six_r   <= 1'b1;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      // a row goes out on every read after the first and on the final cycle
      out_strobe_r <= (state_r == ST_DONE) || (state_r == ST_READ && row_r != '0);
      case (state_r)
        ST_SWEEP: begin
          if (sw_row_r == ROW_LAST) begin
            sw_row_r  <= '0;
            sw_slot_r <= (sw_slot_r == SLOT_LAST) ? '0 : sw_slot_r + 1'b1;
          end else begin
            sw_row_r <= sw_row_r + 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept && in_item.mode == MODE_CLEAR) keep_cur_r <= 1'b1;
          if (accept && in_item.mode == MODE_STEP) begin
            cur_s_r    <= head_r;
            new_s_r    <= newh;
            two_s_r    <= two_s;
            six_s_r    <= six_s;
            head_r     <= newh;
            row_r      <= '0;
            same_two_r <= 1'b1;
            same_six_r <= 1'b1;
          end
        end
        ST_READ: begin
          if (row_r == '0) begin
            w_prev_r <= '0;
            w_cur_r  <= rd_a_r;
          end else begin
            // previous row: six-back data is in, emit it
            same_six_r         <= same_six_r && (nr_r == rd_b_r);
            out_r.out_row      <= ROW_IDX_W'(nr_row_r);
            out_r.out_bits     <= BITS_W'(nr_r);
            out_r.last_row     <= 1'b0;
            out_r.evolving     <= 1'b0;
          end
        end
        ST_CALC: begin
          nr_r       <= rule_out;
          nr_row_r   <= row_r;
          same_two_r <= same_two_r && (rule_out == rd_b_r);
          w_prev_r   <= w_cur_r;
          w_cur_r    <= below;
          if (row_r != ROW_LAST) row_r <= row_r + 1'b1;
        end
        ST_DONE: begin
          same_six_r     <= same_six_r && (nr_r == rd_b_r);
          out_r.out_row  <= ROW_IDX_W'(nr_row_r);
          out_r.out_bits <= BITS_W'(nr_r);
          out_r.last_row <= 1'b1;
          out_r.evolving <= !(same_two_r || (same_six_r && nr_r == rd_b_r));
        end
        default: begin
        end
      endcase
    end
  end

endmodule
